/* src/call_graph_recorder_assert.svh */
// Assertion macros used by the call graph recorder datapath.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef CALL_GRAPH_RECORDER_ASSERT_SVH
`define CALL_GRAPH_RECORDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cgr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgr_pkg
// Types and codes shared by the call graph recorder controller and datapath.
// ----------------------------------------------------------------------------
package cgr_pkg;

    localparam logic [1:0] OP_CALL   = 2'd0;
    localparam logic [1:0] OP_RETURN = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_STACK_FULL = 3'd1;
    localparam logic [2:0] STS_EMPTY      = 3'd2;
    localparam logic [2:0] STS_TABLE_FULL = 3'd3;
    localparam logic [2:0] STS_LIST_FULL  = 3'd4;
    localparam logic [2:0] STS_BAD_READ   = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] func_key;
        logic [6:0]  read_func;
        logic [3:0]  read_slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] func_index;
        logic       is_new_func;
        logic       edge_added;
        logic [8:0] depth;
        logic [6:0] read_callee;
        logic [4:0] read_count;
    } result_t;

    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NONE      = 5'd0;
    localparam cmd_t CMD_LATCH     = 5'd1;
    localparam cmd_t CMD_KEY_RD    = 5'd2;
    localparam cmd_t CMD_KEY_FOUND = 5'd3;
    localparam cmd_t CMD_KEY_NEXT  = 5'd4;
    localparam cmd_t CMD_ERR_FULL  = 5'd5;
    localparam cmd_t CMD_ERR_TABLE = 5'd6;
    localparam cmd_t CMD_SET_IDX   = 5'd7;
    localparam cmd_t CMD_TOP_RD    = 5'd8;
    localparam cmd_t CMD_CNT_RD    = 5'd9;
    localparam cmd_t CMD_CNT_TAKE  = 5'd10;
    localparam cmd_t CMD_LST_RD    = 5'd11;
    localparam cmd_t CMD_LST_NEXT  = 5'd12;
    localparam cmd_t CMD_ERR_LIST  = 5'd13;
    localparam cmd_t CMD_NEED_EDGE = 5'd14;
    localparam cmd_t CMD_COMMIT    = 5'd15;
    localparam cmd_t CMD_EDGE      = 5'd16;
    localparam cmd_t CMD_ERR_EMPTY = 5'd17;
    localparam cmd_t CMD_POP       = 5'd18;
    localparam cmd_t CMD_POP_TAKE  = 5'd19;
    localparam cmd_t CMD_ERR_READ  = 5'd20;
    localparam cmd_t CMD_RD_CNT    = 5'd21;
    localparam cmd_t CMD_ERR_SLOT  = 5'd22;
    localparam cmd_t CMD_RD_LST    = 5'd23;
    localparam cmd_t CMD_RD_TAKE   = 5'd24;

    typedef struct packed {
        logic [1:0] op;
        logic       scan_end;
        logic       key_hit;
        logic       stack_full;
        logic       stack_empty;
        logic       no_slot;
        logic       list_end;
        logic       list_full;
        logic       lst_hit;
        logic       rd_bad_func;
        logic       rd_bad_slot;
    } dp_status_t;

endpackage

/* src/call_graph_recorder.sv */
`timescale 1ns / 1ps
// A call walks the keys in the key table and then the callees in the caller's list,
// one compare at a time; a return or a read walks no list.
// One item at a time: busy stays high until the result cycle has ended.
// Reset empties the stack and the key table; the result cannot be stalled.
// ----------------------------------------------------------------------------
// call_graph_recorder
// Records the distinct callees of each function from a stream of call and
// return items, and answers reads of one callee slot and the callee count.
// ----------------------------------------------------------------------------
module call_graph_recorder
    import cgr_pkg::*;
#(
    parameter int MAX_FUNCS   = 128,
    parameter int MAX_CALLEES = 16,
    parameter int STACK_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  in_item_t item,
    output logic     result_valid,
    output result_t  result
);
    cmd_t       cmd;
    dp_status_t sts;

    cgr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (result_valid)
    );

    cgr_datapath #(
        .MAX_FUNCS   (MAX_FUNCS),
        .MAX_CALLEES (MAX_CALLEES),
        .STACK_DEPTH (STACK_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

/* src/cgr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgr_datapath
// Key table, call stack, callee lists and counts, with the item and result
// registers, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module cgr_datapath
    import cgr_pkg::*;
#(
    parameter int MAX_FUNCS   = 128,
    parameter int MAX_CALLEES = 16,
    parameter int STACK_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  cmd_t       cmd,
    output dp_status_t sts,
    output result_t    result
);
    `include "call_graph_recorder_assert.svh"

    localparam int FW     = $clog2(MAX_FUNCS);
    localparam int NFW    = $clog2(MAX_FUNCS + 1);
    localparam int SW     = $clog2(STACK_DEPTH);
    localparam int DW     = $clog2(STACK_DEPTH + 1);
    localparam int CW     = (MAX_CALLEES > 1) ? $clog2(MAX_CALLEES) : 1;
    localparam int NW     = $clog2(MAX_CALLEES + 1);
    localparam int LW     = FW + CW;
    localparam int LDEPTH = MAX_FUNCS * MAX_CALLEES;

    logic [KEY_WIDTH-1:0] key_mem [MAX_FUNCS];
    logic [FW-1:0]        stack_mem [STACK_DEPTH];
    logic [NW-1:0]        cnt_mem [MAX_FUNCS];
    logic [FW-1:0]        lst_mem [LDEPTH];

    logic [KEY_WIDTH-1:0] key_rdata_reg;
    logic [FW-1:0]        stack_rdata_reg;
    logic [NW-1:0]        cnt_rdata_reg;
    logic [FW-1:0]        lst_rdata_reg;

    in_item_t             item_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [NFW-1:0]       known_reg, known_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [NFW-1:0]       scan_reg;
    logic                 found_reg;
    logic [FW-1:0]        idx_reg;
    logic [FW-1:0]        caller_reg;
    logic [NW-1:0]        n_reg;
    logic [NW-1:0]        j_reg;
    logic                 need_edge_reg;
    logic [2:0]           status_reg;
    logic [6:0]           fidx_reg;
    logic                 isnew_reg;
    logic                 edge_reg;
    logic [6:0]           rcallee_reg;
    logic [4:0]           rcount_reg;

    logic                 stack_re, cnt_re, lst_re;
    logic [SW-1:0]        stack_raddr;
    logic [FW-1:0]        cnt_raddr;
    logic [LW-1:0]        lst_raddr;
    logic                 cnt_we;
    logic [FW-1:0]        cnt_waddr;
    logic [NW-1:0]        cnt_wdata;
    logic                 commit_new, commit_edge;
    logic [LW-1:0]        lst_waddr;

    function automatic logic [LW-1:0] list_addr(input logic [FW-1:0] f, input logic [NW-1:0] s);
        list_addr = LW'(32'(f) * MAX_CALLEES + 32'(s));
    endfunction

    assign sts.op          = item_reg.operation;
    assign sts.scan_end    = (scan_reg >= known_reg);
    assign sts.key_hit     = (key_rdata_reg == key_reg);
    assign sts.stack_full  = (depth_reg >= DW'(STACK_DEPTH));
    assign sts.stack_empty = (depth_reg == '0);
    assign sts.no_slot     = !found_reg && (32'(known_reg) >= MAX_FUNCS);
    assign sts.list_end    = (j_reg >= n_reg);
    assign sts.list_full   = (32'(n_reg) >= MAX_CALLEES);
    assign sts.lst_hit     = (lst_rdata_reg == idx_reg);
    assign sts.rd_bad_func = (32'(item_reg.read_func) >= 32'(known_reg))
                          || (32'(item_reg.read_func) >= MAX_FUNCS);
    assign sts.rd_bad_slot = (32'(item_reg.read_slot) >= 32'(cnt_rdata_reg))
                          || (32'(item_reg.read_slot) >= MAX_CALLEES);

    assign commit_new  = (cmd == CMD_COMMIT) && !found_reg;
    assign commit_edge = (cmd == CMD_COMMIT) && need_edge_reg;
    assign lst_waddr   = list_addr(caller_reg, n_reg);

    // Read port selection; each memory sees one read address per cycle.
    always_comb
    begin
        stack_re    = (cmd == CMD_TOP_RD) || (cmd == CMD_POP);
        stack_raddr = SW'(depth_reg - DW'(1));
        cnt_re      = (cmd == CMD_CNT_RD) || (cmd == CMD_RD_CNT);
        cnt_raddr   = (cmd == CMD_CNT_RD) ? stack_rdata_reg : FW'(item_reg.read_func);
        lst_re      = (cmd == CMD_LST_RD) || (cmd == CMD_RD_LST);
        lst_raddr   = (cmd == CMD_LST_RD) ? list_addr(caller_reg, j_reg)
                    : list_addr(FW'(item_reg.read_func), NW'(item_reg.read_slot));
        cnt_we      = commit_new || ((cmd == CMD_EDGE) && need_edge_reg);
        cnt_waddr   = commit_new ? idx_reg : caller_reg;
        cnt_wdata   = commit_new ? '0 : NW'(n_reg + NW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_KEY_RD)
        begin
            key_rdata_reg <= key_mem[scan_reg[FW-1:0]];
        end
        if (commit_new)
        begin
            key_mem[idx_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_re)
        begin
            stack_rdata_reg <= stack_mem[stack_raddr];
        end
        if (cmd == CMD_COMMIT)
        begin
            stack_mem[SW'(depth_reg)] <= idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lst_re)
        begin
            lst_rdata_reg <= lst_mem[lst_raddr];
        end
        if (commit_edge)
        begin
            lst_mem[lst_waddr] <= idx_reg;
        end
    end

    always_comb
    begin
        known_next = known_reg;
        depth_next = depth_reg;
        if (commit_new)
        begin
            known_next = NFW'(known_reg + NFW'(1));
        end
        if (cmd == CMD_COMMIT)
        begin
            depth_next = DW'(depth_reg + DW'(1));
        end
        else if (cmd == CMD_POP)
        begin
            depth_next = DW'(depth_reg - DW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= '0;
            depth_reg <= '0;
        end
        else
        begin
            known_reg <= known_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LATCH:
            begin
                item_reg      <= item;
                key_reg       <= KEY_WIDTH'(item.func_key);
                scan_reg      <= '0;
                found_reg     <= 1'b0;
                need_edge_reg <= 1'b0;
                status_reg    <= STS_OK;
                fidx_reg      <= '0;
                isnew_reg     <= 1'b0;
                edge_reg      <= 1'b0;
                rcallee_reg   <= '0;
                rcount_reg    <= '0;
            end
            CMD_KEY_FOUND:
            begin
                found_reg <= 1'b1;
                idx_reg   <= scan_reg[FW-1:0];
            end
            CMD_KEY_NEXT:  scan_reg <= NFW'(scan_reg + NFW'(1));
            CMD_ERR_FULL:  status_reg <= STS_STACK_FULL;
            CMD_ERR_TABLE: status_reg <= STS_TABLE_FULL;
            CMD_ERR_LIST:  status_reg <= STS_LIST_FULL;
            CMD_ERR_EMPTY: status_reg <= STS_EMPTY;
            CMD_ERR_READ:  status_reg <= STS_BAD_READ;
            CMD_SET_IDX, CMD_TOP_RD:
            begin
                if (!found_reg)
                begin
                    idx_reg <= FW'(known_reg);
                end
            end
            CMD_CNT_RD:    caller_reg <= stack_rdata_reg;
            CMD_CNT_TAKE:
            begin
                n_reg <= cnt_rdata_reg;
                j_reg <= '0;
            end
            CMD_LST_NEXT:  j_reg <= NW'(j_reg + NW'(1));
            CMD_NEED_EDGE: need_edge_reg <= 1'b1;
            CMD_COMMIT:
            begin
                fidx_reg  <= 7'(idx_reg);
                isnew_reg <= !found_reg;
                edge_reg  <= need_edge_reg;
            end
            CMD_POP_TAKE:  fidx_reg <= 7'(stack_rdata_reg);
            CMD_ERR_SLOT:
            begin
                status_reg <= STS_BAD_READ;
                rcount_reg <= 5'(cnt_rdata_reg);
            end
            CMD_RD_LST:    rcount_reg <= 5'(cnt_rdata_reg);
            CMD_RD_TAKE:
            begin
                rcallee_reg <= 7'(lst_rdata_reg);
                fidx_reg    <= 7'(item_reg.read_func);
            end
            default:
            begin
            end
        endcase
    end

    assign result.status      = status_reg;
    assign result.func_index  = fidx_reg;
    assign result.is_new_func = isnew_reg;
    assign result.edge_added  = edge_reg;
    assign result.depth       = 9'(depth_reg);
    assign result.read_callee = rcallee_reg;
    assign result.read_count  = rcount_reg;

    `CGR_ASSERT_NOW(a_depth_bound, 1'b1, 32'(depth_reg) <= STACK_DEPTH, "stack depth overrun")
    `CGR_ASSERT_NOW(a_known_bound, 1'b1, 32'(known_reg) <= MAX_FUNCS, "key table overrun")
    `CGR_ASSERT_NEXT(a_commit_push, cmd == CMD_COMMIT,
                     depth_reg == DW'($past(depth_reg) + DW'(1)), "commit did not push")

endmodule

/* src/cgr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgr_ctrl
// Sequencer that walks one item at a time through lookup, update and reply.
// ----------------------------------------------------------------------------
module cgr_ctrl
    import cgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t sts,
    output cmd_t       cmd,
    output logic       busy,
    output logic       done
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_KEY_RD  = 4'd2;
    localparam logic [3:0] S_KEY_CMP = 4'd3;
    localparam logic [3:0] S_TOP     = 4'd4;
    localparam logic [3:0] S_CALLER  = 4'd5;
    localparam logic [3:0] S_CNT     = 4'd6;
    localparam logic [3:0] S_LST_RD  = 4'd7;
    localparam logic [3:0] S_LST_CMP = 4'd8;
    localparam logic [3:0] S_COMMIT  = 4'd9;
    localparam logic [3:0] S_EDGE    = 4'd10;
    localparam logic [3:0] S_POP     = 4'd11;
    localparam logic [3:0] S_RD_CNT  = 4'd12;
    localparam logic [3:0] S_RD_LST  = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.op == OP_CALL)
                begin
                    state_next = S_KEY_RD;
                end
                else if (sts.op == OP_RETURN)
                begin
                    cmd        = sts.stack_empty ? CMD_ERR_EMPTY : CMD_POP;
                    state_next = sts.stack_empty ? S_DONE : S_POP;
                end
                else if (sts.op == OP_READ && !sts.rd_bad_func)
                begin
                    cmd        = CMD_RD_CNT;
                    state_next = S_RD_CNT;
                end
                else
                begin
                    cmd        = CMD_ERR_READ;
                    state_next = S_DONE;
                end
            end
            S_KEY_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    cmd        = CMD_KEY_RD;
                    state_next = S_KEY_CMP;
                end
            end
            S_KEY_CMP:
            begin
                cmd        = sts.key_hit ? CMD_KEY_FOUND : CMD_KEY_NEXT;
                state_next = sts.key_hit ? S_TOP : S_KEY_RD;
            end
            S_TOP:
            begin
                if (sts.stack_full)
                begin
                    cmd        = CMD_ERR_FULL;
                    state_next = S_DONE;
                end
                else if (sts.no_slot)
                begin
                    cmd        = CMD_ERR_TABLE;
                    state_next = S_DONE;
                end
                else if (sts.stack_empty)
                begin
                    // The first call on an empty stack has no caller.
                    cmd        = CMD_SET_IDX;
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd        = CMD_TOP_RD;
                    state_next = S_CALLER;
                end
            end
            S_CALLER:
            begin
                cmd        = CMD_CNT_RD;
                state_next = S_CNT;
            end
            S_CNT:
            begin
                cmd        = CMD_CNT_TAKE;
                state_next = S_LST_RD;
            end
            S_LST_RD:
            begin
                if (!sts.list_end)
                begin
                    cmd        = CMD_LST_RD;
                    state_next = S_LST_CMP;
                end
                else if (sts.list_full)
                begin
                    cmd        = CMD_ERR_LIST;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_NEED_EDGE;
                    state_next = S_COMMIT;
                end
            end
            S_LST_CMP:
            begin
                cmd        = sts.lst_hit ? CMD_NONE : CMD_LST_NEXT;
                state_next = sts.lst_hit ? S_COMMIT : S_LST_RD;
            end
            S_COMMIT:
            begin
                cmd        = CMD_COMMIT;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                cmd        = CMD_EDGE;
                state_next = S_DONE;
            end
            S_POP:
            begin
                cmd        = CMD_POP_TAKE;
                state_next = S_DONE;
            end
            S_RD_CNT:
            begin
                cmd        = sts.rd_bad_slot ? CMD_ERR_SLOT : CMD_RD_LST;
                state_next = sts.rd_bad_slot ? S_DONE : S_RD_LST;
            end
            S_RD_LST:
            begin
                cmd        = CMD_RD_TAKE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule
